// ===== src/itrd_pkg.sv =====
package itrd_pkg;

	localparam int MAX_RADIX_DEF  = 16;
	localparam int VALUE_BITS_DEF = 32;

	localparam int RADIX_W     = 5;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 64;
	localparam int CHAR_W      = 8;
	localparam int SYM_IDX_W   = 4;

	localparam logic [CFG_INDEX_W-1:0] CFG_RADIX    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_CHARS_LO = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_CHARS_HI = 2'd2;

	localparam logic [RADIX_W-1:0]    RADIX_RESET    = 5'd10;
	localparam logic [CFG_DATA_W-1:0] CHARS_LO_RESET = 64'd4050765991979987505;
	localparam logic [CFG_DATA_W-1:0] CHARS_HI_RESET = 64'd4702394921427289928;

	localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;

endpackage

// ===== src/itrd_front.sv =====
module itrd_front #(
	parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic signed [VALUE_BITS-1:0] value,
	output logic                         q_valid,
	input  logic                         q_ready,
	output logic                         q_neg,
	output logic        [VALUE_BITS-1:0] q_mag
);

	logic [VALUE_BITS-1:0] v_u;
	logic                  neg_in;
	logic [VALUE_BITS-1:0] mag_in;
	logic                  push_fire;
	logic                  pop_fire;

	logic                  qn_q [2];
	logic [VALUE_BITS-1:0] qm_q [2];
	logic                  wp_q;
	logic                  rp_q;
	logic [1:0]            cnt_q;

	// sign split and two's complement magnitude; most negative value fits unsigned
	assign v_u    = value;
	assign neg_in = v_u[VALUE_BITS-1];
	assign mag_in = neg_in ? (~v_u + 1'b1) : v_u;

	assign full      = (cnt_q == 2'd2);
	assign q_valid   = (cnt_q != 2'd0);
	assign push_fire = push && !full;
	assign pop_fire  = q_valid && q_ready;
	assign q_neg     = qn_q[rp_q];
	assign q_mag     = qm_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push_fire) begin
				wp_q <= ~wp_q;
			end
			if (pop_fire) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= 2'(cnt_q + 2'(push_fire) - 2'(pop_fire));
		end
	end

	always_ff @(posedge clk) begin
		if (push_fire) begin
			qn_q[wp_q] <= neg_in;
			qm_q[wp_q] <= mag_in;
		end
	end

endmodule

// ===== src/itrd_back.sv =====
module itrd_back #(
	parameter int MAX_RADIX  = itrd_pkg::MAX_RADIX_DEF,
	parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEF,
	localparam int DW = $clog2(MAX_RADIX),
	localparam int BW = DW + 1
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [BW-1:0]                        base,
	input  logic [itrd_pkg::CFG_DATA_W-1:0]      chars_lo,
	input  logic [itrd_pkg::CFG_DATA_W-1:0]      chars_hi,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 in_neg,
	input  logic [VALUE_BITS-1:0]                in_mag,
	output logic                                 empty,
	input  logic                                 pop,
	output logic [itrd_pkg::CHAR_W-1:0]          out_char,
	output logic                                 is_last
);

	localparam int NB = (VALUE_BITS + 7) / 8;
	localparam int MW = NB * 8;
	localparam int JW = (NB > 1) ? $clog2(NB) : 1;
	localparam int AW = $clog2(VALUE_BITS);

	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_EMIT} state_t;

	state_t          state_q;
	logic [MW-1:0]   mag_q;
	logic [DW-1:0]   rem_q;
	logic [JW-1:0]   j_q;
	logic [JW-1:0]   hi_q;
	logic [AW-1:0]   wr_idx_q;
	logic [AW-1:0]   ptr_q;
	logic            sign_pend_q;

	logic [DW-1:0]   dig_mem [VALUE_BITS];
	logic [DW-1:0]   rd_data_s1;
	logic            rd_v_s1;
	logic            sign_s1;
	logic            last_s1;

	logic [itrd_pkg::CHAR_W-1:0] ofc_q [2];
	logic                        ofl_q [2];
	logic                        owp_q;
	logic                        orp_q;
	logic [1:0]                  ocnt_q;

	logic [7:0]      byte_cur;
	logic [7:0]      qbyte;
	logic [DW-1:0]   rem_nx;
	logic [MW-1:0]   mag_nx;
	logic            quot_zero;
	logic            hi_zero;
	logic [JW-1:0]   hi_sh;
	logic            digit_done;
	logic            pop_fire;
	logic [2:0]      occ;
	logic            issue;
	logic [itrd_pkg::SYM_IDX_W-1:0] sym_idx;
	logic [2*itrd_pkg::CFG_DATA_W-1:0] sym_table;
	logic [itrd_pkg::CHAR_W-1:0]    fifo_char;

	// one byte of long division per cycle, MSB first
	assign byte_cur = mag_q[8*j_q +: 8];

	always_comb begin
		logic [DW-1:0] r;
		logic [BW-1:0] trial;
		r     = rem_q;
		qbyte = '0;
		for (int i = 7; i >= 0; i--) begin
			trial = {r, byte_cur[i]};
			if (trial >= base) begin
				trial    = trial - base;
				qbyte[i] = 1'b1;
			end
			r = trial[DW-1:0];
		end
		rem_nx = r;
	end

	always_comb begin
		mag_nx = mag_q;
		mag_nx[8*j_q +: 8] = qbyte;
	end

	assign quot_zero  = (mag_nx == '0);
	assign hi_zero    = (mag_nx[8*hi_q +: 8] == 8'd0);
	assign hi_sh      = (hi_zero && hi_q != '0) ? JW'(hi_q - 1'b1) : hi_q;
	assign digit_done = (state_q == ST_DIV) && (j_q == '0);

	assign pop_fire = pop && !empty;
	assign occ      = 3'(ocnt_q) + 3'(rd_v_s1) - 3'(pop_fire);
	assign issue    = (state_q == ST_EMIT) && (occ < 3'd2);
	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			j_q         <= '0;
			hi_q        <= '0;
			wr_idx_q    <= '0;
			ptr_q       <= '0;
			sign_pend_q <= 1'b0;
			rd_v_s1     <= 1'b0;
			sign_s1     <= 1'b0;
			last_s1     <= 1'b0;
		end else begin
			rd_v_s1 <= issue;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q     <= ST_DIV;
						sign_pend_q <= in_neg;
						j_q         <= JW'(NB - 1);
						hi_q        <= JW'(NB - 1);
						wr_idx_q    <= '0;
					end
				end
				ST_DIV: begin
					if (j_q == '0) begin
						wr_idx_q <= AW'(wr_idx_q + 1'b1);
						if (quot_zero) begin
							state_q <= ST_EMIT;
							ptr_q   <= wr_idx_q;
						end else begin
							j_q  <= hi_sh;
							hi_q <= hi_sh;
						end
					end else begin
						j_q <= JW'(j_q - 1'b1);
					end
				end
				ST_EMIT: begin
					if (issue) begin
						if (sign_pend_q) begin
							sign_pend_q <= 1'b0;
							sign_s1     <= 1'b1;
							last_s1     <= 1'b0;
						end else begin
							sign_s1 <= 1'b0;
							last_s1 <= (ptr_q == '0);
							if (ptr_q == '0) begin
								state_q <= ST_IDLE;
							end else begin
								ptr_q <= AW'(ptr_q - 1'b1);
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			mag_q <= MW'(in_mag);
			rem_q <= '0;
		end else if (state_q == ST_DIV) begin
			mag_q <= mag_nx;
			rem_q <= (j_q == '0) ? '0 : rem_nx;
		end
	end

	// digits come out least significant first; stacked, then read back in reverse
	always_ff @(posedge clk) begin
		if (digit_done) begin
			dig_mem[wr_idx_q] <= rem_nx;
		end
		if (issue && !sign_pend_q) begin
			rd_data_s1 <= dig_mem[ptr_q];
		end
	end

	assign sym_table = {chars_hi, chars_lo};

	always_comb begin
		sym_idx = '0;
		sym_idx[DW-1:0] = rd_data_s1;
	end

	assign fifo_char = sign_s1 ? itrd_pkg::MINUS_CHAR : sym_table[8*sym_idx +: 8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owp_q  <= 1'b0;
			orp_q  <= 1'b0;
			ocnt_q <= 2'd0;
		end else begin
			if (rd_v_s1) begin
				owp_q <= ~owp_q;
			end
			if (pop_fire) begin
				orp_q <= ~orp_q;
			end
			ocnt_q <= 2'(ocnt_q + 2'(rd_v_s1) - 2'(pop_fire));
		end
	end

	always_ff @(posedge clk) begin
		if (rd_v_s1) begin
			ofc_q[owp_q] <= fifo_char;
			ofl_q[owp_q] <= last_s1;
		end
	end

	assign empty    = (ocnt_q == 2'd0);
	assign out_char = ofc_q[orp_q];
	assign is_last  = ofl_q[orp_q];

endmodule

// ===== src/integer_to_radix_digits.sv =====
// Signed integer to text in a configurable radix, one character per beat.
// Input side is a queue: drive value with push while full is low. Results are
// a queue too: while empty is low, out_char/is_last hold the oldest character;
// pop takes it. is_last marks the final character of each number. A negative
// value gives a leading minus, then digits most significant first.
// Config: cfg_index 0 = radix (saturated to 2..MAX_RADIX), 1/2 = digit symbol
// table (byte i = symbol of digit i, resp. i+8). Always ready; write only idle.
// A two-entry queue sits between the sign/magnitude front and the divider.
// The divider does one byte of long division per cycle and skips leading zero
// bytes. After the last digit division the first character passes through the
// read stage and then the output queue. Items are converted one at a time; up
// to two wait in the queue. A two-entry output queue absorbs stalls; a stalled
// pop holds the divider once it is ready to emit. Reset empties both queues and
// restores radix 10 and the default symbol table.
module integer_to_radix_digits #(
	parameter int MAX_RADIX  = itrd_pkg::MAX_RADIX_DEF,
	parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic signed [VALUE_BITS-1:0]         value,
	output logic                                 empty,
	input  logic                                 pop,
	output logic        [itrd_pkg::CHAR_W-1:0]   out_char,
	output logic                                 is_last,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic        [itrd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic        [itrd_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int BW = $clog2(MAX_RADIX) + 1;

	logic [itrd_pkg::RADIX_W-1:0]    radix_q;
	logic [itrd_pkg::CFG_DATA_W-1:0] chars_lo_q;
	logic [itrd_pkg::CFG_DATA_W-1:0] chars_hi_q;
	logic [itrd_pkg::RADIX_W-1:0]    radix_sat;
	logic [BW-1:0]                   base;

	logic                  front_valid;
	logic                  front_ready;
	logic                  front_neg;
	logic [VALUE_BITS-1:0] front_mag;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q    <= itrd_pkg::RADIX_RESET;
			chars_lo_q <= itrd_pkg::CHARS_LO_RESET;
			chars_hi_q <= itrd_pkg::CHARS_HI_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				itrd_pkg::CFG_RADIX:    radix_q    <= cfg_data[itrd_pkg::RADIX_W-1:0];
				itrd_pkg::CFG_CHARS_LO: chars_lo_q <= cfg_data;
				itrd_pkg::CFG_CHARS_HI: chars_hi_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		priority if (radix_q < itrd_pkg::RADIX_W'(2)) begin
			radix_sat = itrd_pkg::RADIX_W'(2);
		end else if (radix_q > itrd_pkg::RADIX_W'(MAX_RADIX)) begin
			radix_sat = itrd_pkg::RADIX_W'(MAX_RADIX);
		end else begin
			radix_sat = radix_q;
		end
	end

	assign base = BW'(radix_sat);

	itrd_front #(
		.VALUE_BITS (VALUE_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.value   (value),
		.q_valid (front_valid),
		.q_ready (front_ready),
		.q_neg   (front_neg),
		.q_mag   (front_mag)
	);

	itrd_back #(
		.MAX_RADIX  (MAX_RADIX),
		.VALUE_BITS (VALUE_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.base     (base),
		.chars_lo (chars_lo_q),
		.chars_hi (chars_hi_q),
		.in_valid (front_valid),
		.in_ready (front_ready),
		.in_neg   (front_neg),
		.in_mag   (front_mag),
		.empty    (empty),
		.pop      (pop),
		.out_char (out_char),
		.is_last  (is_last)
	);

	a_back_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		front_valid && front_ready |=> !front_ready)
		else $error("divider took a new item while busy");

	a_full_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> front_valid)
		else $error("input queue full but no item offered to divider");

	a_take_frees_slot: assert property (@(posedge clk) disable iff (!arst_n)
		front_valid && front_ready && !push |=> !full)
		else $error("input queue still full after divider took an item");

endmodule

// ===== tb/sv/tb_integer_to_radix_digits.sv =====
`timescale 1ns / 1ps

module tb_integer_to_radix_digits;

	localparam logic [itrd_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
	localparam int PHASES          = 11;
	localparam int ITEMS_PER_PHASE = 37;
	localparam int HOLD_CYCLES     = 300;
	localparam int DRAIN_CYCLES    = 150;
	localparam int IDLE_LIMIT      = 5000;

	class radix_text_scoreboard;
		typedef struct {
			logic [itrd_pkg::CHAR_W-1:0] ch;
			logic                        last;
		} char_beat_t;

		char_beat_t                        expected_chars[$];
		logic [itrd_pkg::RADIX_W-1:0]      radix_q;
		logic [itrd_pkg::CFG_DATA_W-1:0]   chars_lo_q;
		logic [itrd_pkg::CFG_DATA_W-1:0]   chars_hi_q;
		int                                errors;
		int                                values_seen;
		int                                chars_checked;

		function new();
			radix_q       = itrd_pkg::RADIX_RESET;
			chars_lo_q    = itrd_pkg::CHARS_LO_RESET;
			chars_hi_q    = itrd_pkg::CHARS_HI_RESET;
			errors        = 0;
			values_seen   = 0;
			chars_checked = 0;
		endfunction

		function void set_register(logic [itrd_pkg::CFG_INDEX_W-1:0] idx,
			logic [itrd_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				itrd_pkg::CFG_RADIX:    radix_q = data[itrd_pkg::RADIX_W-1:0];
				itrd_pkg::CFG_CHARS_LO: chars_lo_q = data;
				itrd_pkg::CFG_CHARS_HI: chars_hi_q = data;
				default: ;
			endcase
		endfunction

		// Spell one accepted value into the characters it must produce.
		function void note_value(logic signed [itrd_pkg::VALUE_BITS_DEF-1:0] v);
			logic [itrd_pkg::VALUE_BITS_DEF:0] mag;
			int                                base;
			int                                digits[$];
			int                                d;
			char_beat_t                        beat;
			mag = {v[itrd_pkg::VALUE_BITS_DEF-1], v};
			if (v[itrd_pkg::VALUE_BITS_DEF-1])
				mag = -mag;
			base = radix_q;
			if (base < 2)
				base = 2;
			if (base > itrd_pkg::MAX_RADIX_DEF)
				base = itrd_pkg::MAX_RADIX_DEF;
			do begin
				digits.push_front(int'(mag % base));
				mag = mag / base;
			end while (mag != 0);
			if (v[itrd_pkg::VALUE_BITS_DEF-1]) begin
				beat.ch   = itrd_pkg::MINUS_CHAR;
				beat.last = 1'b0;
				expected_chars.push_back(beat);
			end
			foreach (digits[k]) begin
				d = digits[k];
				if (d < 8)
					beat.ch = chars_lo_q[itrd_pkg::CHAR_W*d +: itrd_pkg::CHAR_W];
				else
					beat.ch = chars_hi_q[itrd_pkg::CHAR_W*(d-8) +: itrd_pkg::CHAR_W];
				beat.last = (k == digits.size() - 1);
				expected_chars.push_back(beat);
			end
			values_seen++;
		endfunction

		function void check_char(logic [itrd_pkg::CHAR_W-1:0] ch, logic last);
			char_beat_t want;
			chars_checked++;
			if (expected_chars.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("ERROR: char %h last %b with nothing expected", ch, last);
				return;
			end
			want = expected_chars.pop_front();
			if (ch !== want.ch || last !== want.last) begin
				errors++;
				if (errors <= 10)
					$display("ERROR: expected char %h last %b, got char %h last %b",
						want.ch, want.last, ch, last);
			end
		endfunction
	endclass

	logic                                         clk       = 1'b0;
	logic                                         arst_n    = 1'b0;
	logic                                         push      = 1'b0;
	logic                                         full;
	logic signed [itrd_pkg::VALUE_BITS_DEF-1:0]   value     = '0;
	logic                                         empty;
	logic                                         pop       = 1'b0;
	logic        [itrd_pkg::CHAR_W-1:0]           out_char;
	logic                                         is_last;
	logic                                         cfg_valid = 1'b0;
	logic                                         cfg_ready;
	logic        [itrd_pkg::CFG_INDEX_W-1:0]      cfg_index = itrd_pkg::CFG_RADIX;
	logic        [itrd_pkg::CFG_DATA_W-1:0]       cfg_data  = '0;

	radix_text_scoreboard sb;
	bit no_gaps      = 1'b0;
	bit hold_pop_req = 1'b0;
	int cfg_writes   = 0;
	int settings_used = 0;
	int idle_cycles  = 0;

	integer_to_radix_digits i_dut (
		.clk,
		.arst_n,
		.push,
		.full,
		.value,
		.empty,
		.pop,
		.out_char,
		.is_last,
		.cfg_valid,
		.cfg_ready,
		.cfg_index,
		.cfg_data
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// push stays high on return so back-to-back beats need no gap
	task automatic send_value(input logic signed [itrd_pkg::VALUE_BITS_DEF-1:0] v);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push  <= 1'b1;
		value <= v;
		do @(posedge clk); while (full);
		sb.note_value(v);
	endtask

	task automatic write_reg(input logic [itrd_pkg::CFG_INDEX_W-1:0] idx,
		input logic [itrd_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_register(idx, data);
		cfg_writes++;
	endtask

	task automatic apply_setting(input logic [itrd_pkg::RADIX_W-1:0] rad,
		input logic [itrd_pkg::CFG_DATA_W-1:0] lo, input logic [itrd_pkg::CFG_DATA_W-1:0] hi);
		logic [itrd_pkg::CFG_DATA_W-1:0] junk;
		junk = {$urandom(), $urandom()};
		write_reg(CFG_UNUSED, {$urandom(), $urandom()});
		write_reg(itrd_pkg::CFG_RADIX,
			{junk[itrd_pkg::CFG_DATA_W-1:itrd_pkg::RADIX_W], rad});
		write_reg(itrd_pkg::CFG_CHARS_LO, lo);
		write_reg(itrd_pkg::CFG_CHARS_HI, hi);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	task automatic wait_drained();
		while (sb.expected_chars.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [itrd_pkg::VALUE_BITS_DEF-1:0] random_value();
		int          pick;
		logic [31:0] mag;
		pick = $urandom_range(0, 9);
		mag  = $urandom() >> $urandom_range(0, 31);
		case (pick)
			0: return $urandom_range(0, 20) - 10;
			1: begin
				case ($urandom_range(0, 3))
					0: return 32'sh8000_0000;
					1: return 32'sh7fff_ffff;
					2: return -1;
					default: return 0;
				endcase
			end
			2, 3, 4: return $urandom_range(0, 1) ? -mag : mag;
			default: return $urandom();
		endcase
	endfunction

	initial begin : watchdog
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("ERROR: no beat accepted for %0d cycles", IDLE_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : result_side
		int gap;
		wait (arst_n === 1'b1);
		forever begin
			gap = no_gaps ? 0 : $urandom_range(0, 5);
			if (hold_pop_req) begin
				hold_pop_req = 1'b0;
				gap = HOLD_CYCLES;
			end
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			sb.check_char(out_char, is_last);
		end
	end

	initial begin : stimulus
		logic signed [itrd_pkg::VALUE_BITS_DEF-1:0] directed_values[$];
		logic        [itrd_pkg::RADIX_W-1:0]        rad;
		logic        [itrd_pkg::CFG_DATA_W-1:0]     lo;
		logic        [itrd_pkg::CFG_DATA_W-1:0]     hi;
		sb = new();
		directed_values = '{0, 1, -1, 9, 10, -10, 99, -100, 32'sh7fff_ffff, 32'sh8000_0000,
			32'sh8000_0001, 255, 65535, 1000000000, -999999999, 123456789, 7, -2147483640};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset radix and symbol table
		foreach (directed_values[i])
			send_value(directed_values[i]);
		push <= 1'b0;
		wait_drained();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: rad = 5'd10;
				1: rad = 5'd2;
				2: rad = 5'd16;
				3: rad = 5'd0;
				4: rad = 5'd1;
				5: rad = 5'd17;
				6: rad = 5'd31;
				7: rad = itrd_pkg::RADIX_W'($urandom_range(0, 31));
				default: rad = itrd_pkg::RADIX_W'($urandom_range(2, 16));
			endcase
			if (p == 0) begin
				lo = itrd_pkg::CHARS_LO_RESET;
				hi = itrd_pkg::CHARS_HI_RESET;
			end else if (p == 3) begin
				lo = '0;
				hi = '1;
			end else if (p == 5) begin
				lo = '1;
				hi = '0;
			end else begin
				lo = {$urandom(), $urandom()};
				hi = {$urandom(), $urandom()};
			end
			apply_setting(rad, lo, hi);
			no_gaps = (p == 1 || p == 6);
			if (p == 1)
				hold_pop_req = 1'b1;
			repeat (ITEMS_PER_PHASE)
				send_value(random_value());
			push <= 1'b0;
			wait_drained();
		end
		no_gaps = 1'b0;

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.expected_chars.size() != 0) begin
			sb.errors++;
			$display("ERROR: %0d expected chars never arrived", sb.expected_chars.size());
		end
		$display("Summary: %0d values spelled into %0d chars under %0d register settings",
			sb.values_seen, sb.chars_checked, settings_used + 1);
		$display("Summary: %0d register writes, radix codes 0..31, %0d mismatches",
			cfg_writes, sb.errors);
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
src/itrd_pkg.sv
src/itrd_front.sv
src/itrd_back.sv
src/integer_to_radix_digits.sv
tb/sv/tb_integer_to_radix_digits.sv
